/* src/wscl_pkg.sv */
// wscl_pkg: shared constants, types and the factory breakpoint table
// for the wind speed count linearizer; no dependencies
package wscl_pkg;

    localparam int NumPoints = 16;
    localparam int IdxW      = 4;
    localparam int CountW    = 16;
    localparam int SpeedW    = 10;
    localparam int QuotW     = 6;
    localparam int NumerW    = 22;

    localparam logic [SpeedW-1:0] SpeedMax  = 10'd600;
    localparam logic [SpeedW-1:0] SpeedOver = 10'd601;

    localparam logic CmdConvert = 1'b0;
    localparam logic CmdWrite   = 1'b1;

    typedef logic [CountW-1:0] count_t;

    // segment setup handed from the search stage to the divider
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic                 zero;
        logic [SpeedW-1:0]    base;
        logic [NumerW-1:0]    numer;
        logic [CountW-1:0]    denom;
    } seg_t;

    function automatic count_t factory_point(input int idx);
        count_t tbl [16];
        tbl = '{16'd45, 16'd80, 16'd160, 16'd248, 16'd333, 16'd420, 16'd507,
                16'd593, 16'd680, 16'd766, 16'd853, 16'd940, 16'd1027,
                16'd1113, 16'd1200, 16'd1287};
        return (idx < 16) ? tbl[idx] : 16'hFFFF;
    endfunction

endpackage

/* src/wscl_divider.sv */
// wscl_divider: pipelined restoring divider, one quotient bit per stage,
// then offset and saturation; uses wscl_pkg
module wscl_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  wscl_pkg::seg_t                seg_in,
    output logic                          out_valid,
    output logic [wscl_pkg::SpeedW-1:0]   out_speed,
    output logic                          out_over
);
    localparam int Q = wscl_pkg::QuotW;
    localparam int RW = wscl_pkg::CountW + 1;

    logic                               v_reg     [Q+1];
    logic                               fz_reg    [Q+1];
    logic                               ok_reg    [Q+1];
    logic [wscl_pkg::SpeedW-1:0]        base_reg  [Q+1];
    logic [wscl_pkg::NumerW-1:0]        num_reg   [Q+1];
    logic [RW-1:0]                      rem_reg   [Q+1];
    logic [wscl_pkg::CountW-1:0]        den_reg   [Q+1];
    logic [Q-1:0]                       quo_reg   [Q+1];
    logic                               ov_v_reg;
    logic [wscl_pkg::SpeedW-1:0]        ov_s_reg;
    logic                               ov_o_reg;

    // stage 0 takes the segment in
    // the quotient fits six bits, so the numerator's upper bits already lie
    // below the divisor and start as the partial remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= seg_in.valid;
        end
        if (en) begin
            fz_reg[0]   <= seg_in.zero;
            ok_reg[0]   <= seg_in.found;
            base_reg[0] <= seg_in.base;
            num_reg[0]  <= {seg_in.numer[Q-1:0], {(wscl_pkg::NumerW-Q){1'b0}}};
            rem_reg[0]  <= {1'b0, seg_in.numer[wscl_pkg::NumerW-1:Q]};
            den_reg[0]  <= seg_in.denom;
            quo_reg[0]  <= '0;
        end
    end

    // one quotient bit per stage, numerator fed msb first
    for (genvar s = 0; s < Q; s++) begin : g_step
        logic [RW:0]   trial;
        logic [RW-1:0] rem_next;
        always_comb begin
            trial = {rem_reg[s], num_reg[s][wscl_pkg::NumerW-1]} - {2'b00, den_reg[s]};
            if (trial[RW]) begin
                rem_next = {rem_reg[s][RW-2:0], num_reg[s][wscl_pkg::NumerW-1]};
            end else begin
                rem_next = trial[RW-1:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s+1] <= 1'b0;
            end else if (en) begin
                v_reg[s+1] <= v_reg[s];
            end
            if (en) begin
                fz_reg[s+1]   <= fz_reg[s];
                ok_reg[s+1]   <= ok_reg[s];
                base_reg[s+1] <= base_reg[s];
                den_reg[s+1]  <= den_reg[s];
                num_reg[s+1]  <= {num_reg[s][wscl_pkg::NumerW-2:0], 1'b0};
                rem_reg[s+1]  <= rem_next;
                quo_reg[s+1]  <= {quo_reg[s][Q-2:0], ~trial[RW]};
            end
        end
    end

    // offset, saturate
    logic [wscl_pkg::SpeedW:0] sum;
    assign sum = {1'b0, base_reg[Q]} + {{(wscl_pkg::SpeedW+1-Q){1'b0}}, quo_reg[Q]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_v_reg <= 1'b0;
        end else if (en) begin
            ov_v_reg <= v_reg[Q];
        end
        if (en) begin
            if (fz_reg[Q]) begin
                ov_s_reg <= '0;
                ov_o_reg <= 1'b0;
            end else if (!ok_reg[Q] || sum > {1'b0, wscl_pkg::SpeedMax}) begin
                ov_s_reg <= wscl_pkg::SpeedOver;
                ov_o_reg <= 1'b1;
            end else begin
                ov_s_reg <= sum[wscl_pkg::SpeedW-1:0];
                ov_o_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_v_reg;
    assign out_speed = ov_s_reg;
    assign out_over  = ov_o_reg;
endmodule

/* src/wind_speed_count_linearizer_core.sv */
// wind_speed_count_linearizer_core: top level, breakpoint table, segment
// search and output register; uses wscl_pkg and wscl_divider
//
// Input channel s_*: command 0 converts s_raw_count to speed in 0.1 m/s,
// command 1 replaces breakpoint s_point_index with s_point_value and gives
// no output word. Output channel m_*: m_speed_tenths and m_over_range,
// 601 with over-range set when no segment fits the count or speed passes 600.
// A convert word passes eleven register stages: compare, segment select,
// numerator scaling, divider input, six divider stages (one quotient bit
// each), then offset and saturation. A new word may enter every cycle
// unless the output register holds an untaken word, so throughput is
// one word per cycle.
// A write takes effect at acceptance; later converts see it.
// Reset (aresetn low, synchronous) reloads the factory table and empties
// the pipeline. While m_valid is high and m_ready low the whole pipeline
// holds; s_ready falls only while the output register holds an untaken word.
module wind_speed_count_linearizer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [15:0]                   s_raw_count,
    input  logic [3:0]                    s_point_index,
    input  logic [15:0]                   s_point_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [9:0]                    m_speed_tenths,
    output logic                          m_over_range
);
    localparam int N = wscl_pkg::NumPoints;

    wscl_pkg::count_t bp_reg [N];
    logic en;
    logic accept;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && s_ready;

    // breakpoint table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) bp_reg[i] <= wscl_pkg::factory_point(i);
        end else if (accept && s_command == wscl_pkg::CmdWrite) begin
            bp_reg[s_point_index] <= s_point_value;
        end
    end

    // stage a: compares against every breakpoint
    logic                 a_v_reg;
    wscl_pkg::count_t     a_x_reg;
    logic [N-1:0]         a_ge_reg;   // x >= Bi
    logic [N-1:0]         a_lt_reg;   // x < Bi
    wscl_pkg::count_t     a_bp_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= accept && s_command == wscl_pkg::CmdConvert;
        end
        if (en) begin
            a_x_reg <= s_raw_count;
            for (int i = 0; i < N; i++) begin
                a_ge_reg[i] <= s_raw_count >= bp_reg[i];
                a_lt_reg[i] <= s_raw_count < bp_reg[i];
                a_bp_reg[i] <= bp_reg[i];
            end
        end
    end

    // stage b: pick the first matching segment
    logic                 b_v_reg, b_found_reg, b_zero_reg;
    logic [1:0]           b_kind_reg;  // 0 first, 1 second, 2 later
    logic [wscl_pkg::SpeedW-1:0] b_base_reg;
    wscl_pkg::count_t     b_diff_reg, b_den_reg;

    logic                 sel_found;
    logic [1:0]           sel_kind;
    logic [wscl_pkg::SpeedW-1:0] sel_base;
    wscl_pkg::count_t     sel_lo, sel_hi;

    always_comb begin
        sel_found = 1'b0;
        sel_kind  = 2'd2;
        sel_base  = '0;
        sel_lo    = '0;
        sel_hi    = a_bp_reg[0];
        if (!a_ge_reg[0] || a_x_reg == a_bp_reg[0]) begin
            sel_found = 1'b1;
            sel_kind  = 2'd0;
        end else if (!a_ge_reg[1] || a_x_reg == a_bp_reg[1]) begin
            sel_found = 1'b1;
            sel_kind  = 2'd1;
            sel_base  = 10'd30;
            sel_lo    = a_bp_reg[0];
            sel_hi    = a_bp_reg[1];
        end else begin
            for (int i = N - 1; i >= 2; i--) begin
                if (a_ge_reg[i-1] && a_lt_reg[i]) begin
                    sel_found = 1'b1;
                    sel_base  = wscl_pkg::SpeedW'(50 * (i - 1));
                    sel_lo    = a_bp_reg[i-1];
                    sel_hi    = a_bp_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= a_v_reg;
        end
        if (en) begin
            b_found_reg <= sel_found;
            b_zero_reg  <= a_x_reg == '0;
            b_kind_reg  <= sel_kind;
            b_base_reg  <= sel_base;
            b_diff_reg  <= a_x_reg - sel_lo;
            b_den_reg   <= sel_hi - sel_lo;
        end
    end

    // stage c: scale numerator by the segment span in tenths
    wscl_pkg::seg_t c_seg_reg;
    logic [wscl_pkg::NumerW-1:0] scaled;

    always_comb begin
        unique case (b_kind_reg)
            2'd0:    scaled = wscl_pkg::NumerW'(b_diff_reg) * 22'd30;
            2'd1:    scaled = wscl_pkg::NumerW'(b_diff_reg) * 22'd20;
            default: scaled = wscl_pkg::NumerW'(b_diff_reg) * 22'd50;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_seg_reg.valid <= 1'b0;
        end else if (en) begin
            c_seg_reg.valid <= b_v_reg;
        end
        if (en) begin
            c_seg_reg.found <= b_found_reg;
            c_seg_reg.zero  <= b_zero_reg;
            c_seg_reg.base  <= b_base_reg;
            c_seg_reg.numer <= scaled;
            c_seg_reg.denom <= b_den_reg;
        end
    end

    wscl_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .seg_in    (c_seg_reg),
        .out_valid (m_valid),
        .out_speed (m_speed_tenths),
        .out_over  (m_over_range)
    );
endmodule

/* src/wscl_checker.sv */
// wscl_checker: port-level assertions for the linearizer core and the bind
// that attaches them; no package dependency
module wscl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_speed_tenths,
    input logic       m_over_range
);
    // over-range flag matches the saturation code
    a_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_over_range == (m_speed_tenths == 10'd601)))
        else $error("over_range mismatch");

    // results never exceed the saturation code
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_speed_tenths <= 10'd601)
        else $error("speed out of range");

    // input side is ready whenever no output word waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed_tenths))
        else $error("stalled output changed");

    // an offered input word stays offered until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input word withdrawn");
endmodule

bind wind_speed_count_linearizer_core wscl_checker u_wscl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_speed_tenths(m_speed_tenths),
    .m_over_range(m_over_range)
);

/* tb/sv/wind_speed_count_linearizer_core_tb.sv */
// wind_speed_count_linearizer_core_tb: self-checking bench for the linearizer core
// depends on wscl_pkg and wind_speed_count_linearizer_core
module wind_speed_count_linearizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        cmd;
        logic [15:0] raw;
        logic [3:0]  idx;
        logic [15:0] val;
        int          pause_after;
    } word_t;

    typedef struct {
        logic [9:0] speed;
        logic       over;
    } speed_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = wscl_pkg::CmdConvert;
    logic [15:0] s_raw_count = '0;
    logic [3:0] s_point_index = '0;
    logic [15:0] s_point_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [9:0] m_speed_tenths;
    logic m_over_range;

    word_t  pending_words[$];
    speed_t expected_speeds[$];
    wscl_pkg::count_t table_model[wscl_pkg::NumPoints];
    int     send_idle_pct = 17;
    int     recv_idle_pct = 58;
    int     hold_off = 0;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     pause_left = 0;
    int     errors = 0;
    int     converts_seen = 0;
    int     writes_sent = 0;
    int     cycle_count = 0;

    wind_speed_count_linearizer_core i_dut (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // interpolation over the current breakpoint table
    function automatic speed_t interpolate_speed(input logic [15:0] x);
        speed_t r;
        int unsigned s;
        int unsigned lo;
        int unsigned hi;
        bit hit;
        s = 0;
        hit = 1'b0;
        if (x == 0) begin
            hit = 1'b1;
        end else if (x <= table_model[0]) begin
            s = (30 * x) / table_model[0];
            hit = 1'b1;
        end else if (x <= table_model[1]) begin
            s = 30 + (20 * (x - table_model[0])) / (table_model[1] - table_model[0]);
            hit = 1'b1;
        end else begin
            for (int i = 2; i < wscl_pkg::NumPoints && !hit; i++) begin
                lo = table_model[i-1];
                hi = table_model[i];
                if (x >= lo && x < hi) begin
                    s = 50 * (i - 1) + (50 * (x - lo)) / (hi - lo);
                    hit = 1'b1;
                end
            end
        end
        if (!hit || s > wscl_pkg::SpeedMax) begin
            r.speed = wscl_pkg::SpeedOver;
            r.over = 1'b1;
        end else begin
            r.speed = s[9:0];
            r.over = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        errors++;
    endtask

    function automatic word_t convert_word(input logic [15:0] x);
        word_t w;
        w = '{wscl_pkg::CmdConvert, x, 4'($urandom), 16'($urandom), 0};
        return w;
    endfunction

    function automatic word_t write_word(input logic [3:0] i, input logic [15:0] v);
        word_t w;
        w = '{wscl_pkg::CmdWrite, 16'($urandom), i, v, 0};
        return w;
    endfunction

    // driver: model updated and expectation queued at acceptance
    always @(posedge aclk) begin
        speed_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_command == wscl_pkg::CmdWrite) begin
                    table_model[s_point_index] = s_point_value;
                    writes_sent++;
                end else begin
                    e = interpolate_speed(s_raw_count);
                    expected_speeds.push_back(e);
                end
            end
            if (pause_left > 0 && expected_speeds.size() == 0)
                pause_left = 0;
            if (s_valid && !s_ready) begin
                // hold the word
            end else if (pause_left == 0 && pending_words.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                word_t w;
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_command <= w.cmd;
                s_raw_count <= w.raw;
                s_point_index <= w.idx;
                s_point_value <= w.val;
                pause_left = w.pause_after;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off counter, started on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_off <= 200;
            hold_seen <= hold_req;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // monitor and receiver ready
    always @(posedge aclk) begin
        speed_t e;
        cycle_count++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                converts_seen++;
                if (expected_speeds.size() == 0) begin
                    report_mismatch("unexpected word", m_speed_tenths, -1);
                end else begin
                    e = expected_speeds.pop_front();
                    if (m_speed_tenths !== e.speed)
                        report_mismatch("speed_tenths", m_speed_tenths, e.speed);
                    if (m_over_range !== e.over)
                        report_mismatch("over_range", m_over_range, e.over);
                end
            end
            m_ready <= (hold_off == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
        if (cycle_count > 400000) begin
            $display("timeout with %0d words outstanding", expected_speeds.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // random word: mostly in-table counts, sometimes writes
    function automatic word_t random_word();
        int r;
        logic [15:0] x;
        r = $urandom_range(99);
        if (r < 8)
            return write_word(4'($urandom), 16'($urandom_range(1, 1400)));
        if (r < 10)
            return write_word(4'($urandom), 16'($urandom));
        if (r < 80)
            x = 16'($urandom_range(0, 1400));
        else if (r < 90)
            x = 16'($urandom);
        else
            x = table_model[$urandom_range(wscl_pkg::NumPoints-1)]
                + 16'($urandom_range(0, 2)) - 16'd1;
        return convert_word(x);
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_valid || expected_speeds.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        word_t w;
        for (int i = 0; i < wscl_pkg::NumPoints; i++)
            table_model[i] = wscl_pkg::factory_point(i);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, breakpoints, segment edges, writes
        pending_words.push_back(convert_word(16'd0));
        pending_words.push_back(convert_word(16'd1));
        pending_words.push_back(convert_word(16'd45));
        pending_words.push_back(convert_word(16'd46));
        pending_words.push_back(convert_word(16'd80));
        pending_words.push_back(convert_word(16'd81));
        pending_words.push_back(convert_word(16'd1286));
        pending_words.push_back(convert_word(16'd1287));
        pending_words.push_back(convert_word(16'hFFFF));
        pending_words.push_back(convert_word(16'd700));
        // non-monotonic gap and over range
        pending_words.push_back(write_word(4'd5, 16'd200));
        pending_words.push_back(convert_word(16'd300));
        pending_words.push_back(write_word(4'd15, 16'hFFFF));
        pending_words.push_back(convert_word(16'hFFFE));
        pending_words.push_back(write_word(4'd14, 16'd1201));
        pending_words.push_back(convert_word(16'd1200));
        pending_words.push_back(write_word(4'd0, 16'hFFFF));
        pending_words.push_back(convert_word(16'hFFFF));
        pending_words.push_back(convert_word(16'd1));
        pending_words.push_back(write_word(4'd0, 16'd45));
        pending_words.push_back(write_word(4'd5, 16'd420));
        pending_words.push_back(write_word(4'd15, 16'd1287));
        w = write_word(4'd14, 16'd1200);
        w.pause_after = 1;
        pending_words.push_back(w);
        pending_words.push_back(convert_word(16'd1199));
        wait_drained();

        // long receiver stall while the sender keeps offering
        send_idle_pct = 0;
        hold_req++;
        for (int i = 0; i < 40; i++)
            pending_words.push_back(convert_word(16'($urandom_range(0, 1400))));
        wait_drained();

        // random phases with swapped idling, then none
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 58 : 0;
            recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 17 : 0;
            for (int i = 0; i < 260; i++) begin
                w = random_word();
                if ($urandom_range(99) == 0)
                    w.pause_after = 1;
                pending_words.push_back(w);
            end
            wait_drained();
        end

        $display("covered %0d conversions and %0d table writes", converts_seen, writes_sent);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* wind_speed_count_linearizer_core.f */
src/wscl_pkg.sv
src/wscl_divider.sv
src/wind_speed_count_linearizer_core.sv
src/wscl_checker.sv
tb/sv/wind_speed_count_linearizer_core_tb.sv
